FILE: src/esd_pkg.sv
// Shared definitions for the escape sequence decoder.
// Holds the decoder mode codes, the character constants and the result record type.
// Depends on nothing; used by esd_decode and escape_sequence_decoder.
package esd_pkg;

    localparam int CharWidth = 8;

    // Decoder modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_OCT    = 2'd2;
    localparam logic [1:0] MODE_HEX    = 2'd3;

    // Characters that steer the decoder
    localparam logic [CharWidth-1:0] CH_NUL       = 8'h00;
    localparam logic [CharWidth-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CharWidth-1:0] CH_ZERO      = 8'h30;
    localparam logic [CharWidth-1:0] CH_SEVEN     = 8'h37;
    localparam logic [CharWidth-1:0] CH_NINE      = 8'h39;
    localparam logic [CharWidth-1:0] CH_LOWER_A   = 8'h61;
    localparam logic [CharWidth-1:0] CH_LOWER_F   = 8'h66;
    localparam logic [CharWidth-1:0] CH_LOWER_X   = 8'h78;
    localparam logic [CharWidth-1:0] CH_LOWER_T   = 8'h74;
    localparam logic [CharWidth-1:0] CH_LOWER_N   = 8'h6E;
    localparam logic [CharWidth-1:0] CH_LOWER_B   = 8'h62;
    localparam logic [CharWidth-1:0] CH_LOWER_R   = 8'h72;
    localparam logic [CharWidth-1:0] CH_LOWER_V   = 8'h76;

    // Control characters produced by the letter escapes
    localparam logic [CharWidth-1:0] CTRL_BEL = 8'd7;
    localparam logic [CharWidth-1:0] CTRL_BS  = 8'd8;
    localparam logic [CharWidth-1:0] CTRL_HT  = 8'd9;
    localparam logic [CharWidth-1:0] CTRL_LF  = 8'd10;
    localparam logic [CharWidth-1:0] CTRL_VT  = 8'd11;
    localparam logic [CharWidth-1:0] CTRL_FF  = 8'd12;
    localparam logic [CharWidth-1:0] CTRL_CR  = 8'd13;

    // Depth of the result queue: one waiting result plus two from a new byte
    localparam int QueueDepth = 3;

    typedef struct packed {
        logic [CharWidth-1:0] char_out;
        logic                 end_of_string;
        logic                 run_last;
    } result_t;

    // What one input byte produces and leaves behind
    typedef struct packed {
        logic [1:0]           count;
        result_t              first;
        result_t              second;
        logic [1:0]           mode;
        logic [CharWidth-1:0] value;
    } decode_t;

endpackage

FILE: src/esd_decode.sv
// Single-pass decode of one input byte against the current decoder state.
// Produces up to two results and the next mode and accumulator value.
// Depends on esd_pkg.
module esd_decode import esd_pkg::*; (
    input  logic [1:0]           mode,
    input  logic [CharWidth-1:0] value,
    input  logic [CharWidth-1:0] char_in,
    output decode_t              dec
);

    logic                 is_oct;
    logic                 is_dec;
    logic                 is_hexl;
    logic [3:0]           hex_digit;
    logic [CharWidth-1:0] esc_char;

    assign is_oct  = (char_in >= CH_ZERO) && (char_in <= CH_SEVEN);
    assign is_dec  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    assign is_hexl = (char_in >= CH_LOWER_A) && (char_in <= CH_LOWER_F);

    always_comb begin
        if (is_hexl) begin
            hex_digit = 4'(char_in - CH_LOWER_A + 8'd10);
        end else begin
            hex_digit = char_in[3:0];
        end
    end

    always_comb begin
        case (char_in)
            CH_LOWER_T: esc_char = CTRL_HT;
            CH_LOWER_N: esc_char = CTRL_LF;
            CH_LOWER_B: esc_char = CTRL_BS;
            CH_LOWER_A: esc_char = CTRL_BEL;
            CH_LOWER_F: esc_char = CTRL_FF;
            CH_LOWER_R: esc_char = CTRL_CR;
            CH_LOWER_V: esc_char = CTRL_VT;
            default:    esc_char = char_in;
        endcase
    end

    // Normal-mode handling of a byte, placed into the given result slot.
    function automatic decode_t copy_byte(input decode_t d, input logic [CharWidth-1:0] c,
                                          input logic second_slot);
        decode_t r;
        result_t res;
        r   = d;
        res = '{char_out: c, end_of_string: 1'b0, run_last: 1'b1};
        if (c == CH_NUL) begin
            r.mode  = MODE_NORMAL;
            r.value = '0;
            res.end_of_string = 1'b1;
        end else if (c == CH_BACKSLASH) begin
            r.mode = MODE_ESC;
        end else begin
            r.mode = MODE_NORMAL;
        end
        if (c != CH_BACKSLASH) begin
            if (second_slot) begin
                r.second = res;
            end else begin
                r.first = res;
            end
            r.count = r.count + 2'd1;
        end
        return r;
    endfunction

    always_comb begin
        decode_t d;
        d        = '0;
        d.mode   = mode;
        d.value  = value;
        case (mode)
            MODE_NORMAL: begin
                d = copy_byte(d, char_in, 1'b0);
            end
            MODE_ESC: begin
                if (char_in == CH_NUL) begin
                    d = copy_byte(d, char_in, 1'b0);
                end else if (is_oct) begin
                    d.mode  = MODE_OCT;
                    d.value = {5'd0, char_in[2:0]};
                end else if (char_in == CH_LOWER_X) begin
                    d.mode  = MODE_HEX;
                    d.value = '0;
                end else begin
                    d.mode  = MODE_NORMAL;
                    d.first = '{char_out: esc_char, end_of_string: 1'b0, run_last: 1'b1};
                    d.count = 2'd1;
                end
            end
            MODE_OCT, MODE_HEX: begin
                if (mode == MODE_OCT && is_oct) begin
                    d.value = {value[CharWidth-4:0], char_in[2:0]};
                end else if (mode == MODE_HEX && (is_dec || is_hexl)) begin
                    d.value = {value[CharWidth-5:0], hex_digit};
                end else begin
                    // The run ends: its value goes out first, then the byte is copied.
                    d.first = '{char_out: value, end_of_string: 1'b0, run_last: 1'b1};
                    d.count = 2'd1;
                    d.value = '0;
                    d = copy_byte(d, char_in, 1'b1);
                    if (d.count == 2'd2) begin
                        d.first.run_last = 1'b0;
                    end
                end
            end
            default: begin
                d = copy_byte(d, char_in, 1'b0);
            end
        endcase
        dec = d;
    end

endmodule

FILE: src/escape_sequence_decoder.sv
// Top level of the C escape sequence decoder: stream ports, state and result queue.
// Instantiates esd_decode; depends on esd_pkg.
//
// The decoder takes a text stream one byte per request on the s_ side and
// resolves C backslash escapes. Plain bytes pass straight through; a backslash
// followed by one of the usual letters gives the matching control character,
// and any other character after a backslash is passed on without it. Octal
// digit runs, and lowercase hex digit runs introduced by x, accumulate into a
// single byte that wraps modulo 256; the value leaves the block when the first
// non-digit arrives, and that byte is then treated as ordinary input. Byte zero
// ends a string, is delivered with m_tlast set, and returns the decoder to its
// plain copying state. One input byte gives no result (a backslash or a digit
// inside a run), one result, or two (a run value followed by the byte that
// ended it); m_tuser marks the last result caused by each input byte. A byte
// is decoded in the cycle it is accepted and its results enter a three-entry
// output queue, so one byte is taken every cycle while each byte yields at
// most one result and the m_ side takes every result; a byte that yields two
// results costs the m_ side an extra transfer, which the queue absorbs by
// holding s_tready low when it cannot take another pair. Results are
// registered in the queue before they reach the m_ side.
module escape_sequence_decoder import esd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input bytes
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CharWidth-1:0] s_tdata,   // [7:0] char_in
    // Decoded bytes
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CharWidth-1:0] m_tdata,   // [7:0] char_out
    output logic                 m_tlast,   // end_of_string
    output logic                 m_tuser    // [0] run_last
);

    localparam int CntWidth = $clog2(QueueDepth + 1);

    // Decoder state
    logic [1:0]           mode_reg,  mode_next;
    logic [CharWidth-1:0] value_reg, value_next;

    // Result queue; the head always sits in entry zero.
    result_t              queue_reg [QueueDepth];
    result_t              queue_next [QueueDepth];
    logic [CntWidth-1:0]  count_reg, count_next;

    decode_t              dec;
    logic                 s_accept;
    logic                 m_pop;
    logic [CntWidth-1:0]  count_after_pop;

    esd_decode u_decode (
        .mode    (mode_reg),
        .value   (value_reg),
        .char_in (s_tdata),
        .dec     (dec)
    );

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = queue_reg[0].char_out;
    assign m_tlast  = queue_reg[0].end_of_string;
    assign m_tuser  = queue_reg[0].run_last;

    assign m_pop           = m_tvalid && m_tready;
    assign count_after_pop = count_reg - CntWidth'(m_pop);

    // A new byte may bring two results, so room for two must exist after the pop.
    assign s_tready = (count_after_pop <= CntWidth'(QueueDepth - 2));
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        mode_next  = mode_reg;
        value_next = value_reg;
        if (s_accept) begin
            mode_next  = dec.mode;
            value_next = dec.value;
        end
    end

    always_comb begin
        for (int i = 0; i < QueueDepth; i++) begin
            if (m_pop && (i < QueueDepth - 1)) begin
                queue_next[i] = queue_reg[i + 1];
            end else begin
                queue_next[i] = queue_reg[i];
            end
        end
        if (s_accept) begin
            for (int i = 0; i < QueueDepth; i++) begin
                if ((dec.count != 2'd0) && (CntWidth'(i) == count_after_pop)) begin
                    queue_next[i] = dec.first;
                end
                if ((dec.count == 2'd2) && (CntWidth'(i) == count_after_pop + CntWidth'(1))) begin
                    queue_next[i] = dec.second;
                end
            end
            count_next = count_after_pop + CntWidth'(dec.count);
        end else begin
            count_next = count_after_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            value_reg <= '0;
            count_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

    // Queue payload carries no reset; the count says which entries are live.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < QueueDepth; i++) begin
            queue_reg[i] <= queue_next[i];
        end
    end

endmodule

FILE: test/esd_decode_checker.sv
// Checker for the escape sequence decoder: watches both stream channels, predicts the
// decoded bytes of every accepted request and compares them with what the block delivers.
// Depends on esd_pkg for the mode codes, the character constants and result_t.
module esd_decode_checker import esd_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [CharWidth-1:0] s_tdata,   // [7:0] char_in
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [CharWidth-1:0] m_tdata,   // [7:0] char_out
    input  logic                 m_tlast,   // end_of_string
    input  logic                 m_tuser,   // [0] run_last
    output int                   failures,
    output int                   results_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxReports = 10;

    logic [1:0]           decoder_mode = MODE_NORMAL;
    logic [CharWidth-1:0] run_value = '0;
    result_t              expected_chars [$];
    int                   mismatch_count = 0;
    int                   waiting_count = 0;
    int                   results_seen = 0;

    assign failures        = mismatch_count;
    assign results_waiting = waiting_count;

    function automatic int hex_value(input logic [CharWidth-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return int'(c) - int'(CH_LOWER_A) + 10;
        return -1;
    endfunction

    function automatic logic [CharWidth-1:0] letter_escape(input logic [CharWidth-1:0] c);
        case (c)
            CH_LOWER_T: return CTRL_HT;
            CH_LOWER_N: return CTRL_LF;
            CH_LOWER_B: return CTRL_BS;
            CH_LOWER_A: return CTRL_BEL;
            CH_LOWER_F: return CTRL_FF;
            CH_LOWER_R: return CTRL_CR;
            CH_LOWER_V: return CTRL_VT;
            default:    return c;
        endcase
    endfunction

    task automatic expect_char(input logic [CharWidth-1:0] c, input logic eos);
        result_t r;
        r.char_out      = c;
        r.end_of_string = eos;
        r.run_last      = 1'b0;
        expected_chars.push_back(r);
    endtask

    // A byte seen in plain copying mode.
    task automatic copy_plain(input logic [CharWidth-1:0] c);
        if (c == CH_NUL) begin
            decoder_mode = MODE_NORMAL;
            run_value    = '0;
            expect_char(CH_NUL, 1'b1);
        end else if (c == CH_BACKSLASH) begin
            decoder_mode = MODE_ESC;
        end else begin
            decoder_mode = MODE_NORMAL;
            expect_char(c, 1'b0);
        end
    endtask

    // A byte that ends a numeric run: the run value goes out first.
    task automatic close_run(input logic [CharWidth-1:0] c);
        expect_char(run_value, 1'b0);
        run_value = '0;
        copy_plain(c);
    endtask

    task automatic predict_decode(input logic [CharWidth-1:0] c);
        int queued;
        int digit;
        queued = expected_chars.size();
        case (decoder_mode)
            MODE_NORMAL: begin
                copy_plain(c);
            end
            MODE_ESC: begin
                if (c == CH_NUL) begin
                    copy_plain(c);
                end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                    decoder_mode = MODE_OCT;
                    run_value    = c - CH_ZERO;
                end else if (c == CH_LOWER_X) begin
                    decoder_mode = MODE_HEX;
                    run_value    = '0;
                end else begin
                    decoder_mode = MODE_NORMAL;
                    expect_char(letter_escape(c), 1'b0);
                end
            end
            MODE_OCT: begin
                if (c >= CH_ZERO && c <= CH_SEVEN)
                    run_value = {run_value[CharWidth-4:0], 3'b000} + (c - CH_ZERO);
                else
                    close_run(c);
            end
            default: begin
                digit = hex_value(c);
                if (digit >= 0)
                    run_value = {run_value[CharWidth-5:0], 4'b0000} + digit[3:0];
                else
                    close_run(c);
            end
        endcase
        if (expected_chars.size() > queued)
            expected_chars[expected_chars.size() - 1].run_last = 1'b1;
    endtask

    task automatic report_mismatch(input string wanted);
        mismatch_count++;
        if (mismatch_count <= MaxReports)
            $display("result %0d: expected %s, got data %02h last %b user %b",
                     results_seen, wanted, m_tdata, m_tlast, m_tuser);
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            decoder_mode = MODE_NORMAL;
            run_value    = '0;
            expected_chars.delete();
        end else begin
            // Results leave no earlier than the cycle after their request, so the
            // comparison comes before the prediction for this edge's request.
            if (m_tvalid && m_tready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("nothing");
                end else begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.char_out || m_tlast !== want.end_of_string
                        || m_tuser !== want.run_last)
                        report_mismatch($sformatf("data %02h last %b user %b",
                                        want.char_out, want.end_of_string, want.run_last));
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
                predict_decode(s_tdata);
        end
        waiting_count <= expected_chars.size();
    end

endmodule

FILE: test/escape_sequence_decoder_test.sv
// Testbench top for the escape sequence decoder: clock, reset, byte stimulus and verdict.
// Depends on esd_pkg, escape_sequence_decoder and esd_decode_checker.
module escape_sequence_decoder_test import esd_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClockPeriod = 8;
    localparam int ResetCycles = 12;
    localparam int PhaseChars  = 250;   // requests per idling phase
    localparam int LongHold    = 300;   // cycles of the long receiver hold-off
    localparam int IdleLimit   = 2000;  // cycles with no transfer on either side before giving up
    localparam int DrainCycles = 16;    // quiet cycles at the end to catch stray results

    // Characters that the package does not name but the stimulus needs.
    localparam logic [CharWidth-1:0] CH_QUOTE    = 8'h27;
    localparam logic [CharWidth-1:0] CH_DQUOTE   = 8'h22;
    localparam logic [CharWidth-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CharWidth-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CharWidth-1:0] CH_UPPER_F  = 8'h46;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CharWidth-1:0] s_tdata = '0;     // [7:0] char_in
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CharWidth-1:0] m_tdata;          // [7:0] char_out
    logic                 m_tlast;          // end_of_string
    logic                 m_tuser;          // [0] run_last

    int failures;
    int results_waiting;

    // Idling controls, written only by the stimulus process.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int chars_sent = 0;

    logic [CharWidth-1:0] escape_letters [$];
    logic [CharWidth-1:0] opening_text [$];

    always #(ClockPeriod / 2) aclk = ~aclk;

    escape_sequence_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    esd_decode_checker decode_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .failures        (failures),
        .results_waiting (results_waiting)
    );

    // The receiver decides m_tready afresh every cycle. A long hold-off is asked for
    // by bumping hold_requests; this process then counts the stretch down itself, so
    // that the sender carries on offering bytes and the result queue fills up.
    int hold_left = 0;
    int holds_started = 0;

    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_started != hold_requests) begin
            holds_started <= holds_started + 1;
            hold_left     <= LongHold;
            m_tready      <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a run in which nothing moves on either side for too long has hung.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IdleLimit) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one byte and returns just after the edge at which it was accepted.
    // s_tvalid stays high between back-to-back requests and is only lowered for
    // an idle gap, so it never sees two assignments in the same time step.
    task automatic offer_char(input logic [CharWidth-1:0] c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge aclk);
        while (!s_tready);
        chars_sent++;
    endtask

    // Stops sending and waits until every predicted result has been delivered.
    // The first edge lets the checker take in the request accepted last.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_waiting != 0)
            @(posedge aclk);
    endtask

    function automatic logic [CharWidth-1:0] random_hex_digit();
        int d;
        d = $urandom_range(15);
        return CharWidth'((d < 10) ? CH_ZERO + d : CH_LOWER_A + (d - 10));
    endfunction

    // One random fragment of text. Four fragments in ten, on average, are escapes
    // with random content; the rest is plain text, terminators and raw noise, which
    // also breaks escapes that are still open.
    task automatic offer_fragment();
        int kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: begin
                offer_char(CharWidth'($urandom_range(1, 255)));
            end
            3: begin
                offer_char(CH_BACKSLASH);
                offer_char(escape_letters[$urandom_range(escape_letters.size() - 1)]);
            end
            4: begin
                // A random byte after a backslash; unknown letters pass through without it.
                offer_char(CH_BACKSLASH);
                offer_char(CharWidth'($urandom_range(255)));
            end
            5: begin
                // Octal runs of one to five digits; the longer ones can wrap round.
                offer_char(CH_BACKSLASH);
                repeat ($urandom_range(1, 5))
                    offer_char(CharWidth'(CH_ZERO + $urandom_range(7)));
            end
            6: begin
                // Hex runs, sometimes empty, sometimes cut short by a capital letter.
                offer_char(CH_BACKSLASH);
                offer_char(CH_LOWER_X);
                repeat ($urandom_range(0, 4))
                    offer_char(random_hex_digit());
                if ($urandom_range(3) == 0)
                    offer_char(CharWidth'(CH_UPPER_A
                                          + $urandom_range(CH_UPPER_F - CH_UPPER_A)));
            end
            7: begin
                offer_char(CH_NUL);
            end
            default: begin
                offer_char(CharWidth'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic with_hold);
        int   target;
        logic hold_done;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target    = chars_sent + PhaseChars;
        hold_done = 1'b0;
        while (chars_sent < target) begin
            // Part way into the phase the receiver holds off for a long stretch.
            if (with_hold && !hold_done && chars_sent >= target - PhaseChars + 40) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            offer_fragment();
        end
        drain_results();
    endtask

    initial begin
        escape_letters = '{CH_LOWER_T, CH_LOWER_N, CH_LOWER_B, CH_LOWER_A, CH_LOWER_F,
                           CH_LOWER_R, CH_LOWER_V, CH_QUOTE, CH_DQUOTE, CH_QUESTION,
                           CH_BACKSLASH};

        // Opening text: the largest and a small plain byte, a letter escape, a quote
        // escape, an unknown letter, an octal run that wraps and is ended by a
        // backslash, a hex run ended by a capital letter, a terminator straight after
        // a backslash, an empty hex run ended by a terminator, and two more letters.
        opening_text = '{8'hFF, 8'h01,
                         CH_BACKSLASH, CH_LOWER_T,
                         CH_BACKSLASH, CH_DQUOTE,
                         CH_BACKSLASH, 8'h71,
                         CH_BACKSLASH, 8'h33, CH_SEVEN, CH_SEVEN, CH_SEVEN,
                         CH_BACKSLASH, CH_LOWER_X, CH_LOWER_F, CH_UPPER_F,
                         CH_BACKSLASH, CH_NUL,
                         CH_BACKSLASH, CH_LOWER_X, CH_NUL,
                         CH_BACKSLASH, CH_LOWER_A,
                         CH_BACKSLASH, CH_LOWER_V};

        repeat (ResetCycles)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_text[i])
            offer_char(opening_text[i]);
        drain_results();

        // Random text through the idling phases; every phase ends with the sender
        // paused until all outstanding results have come back.
        run_phase(0, 0, 1'b1);
        run_phase(77, 0, 1'b0);
        run_phase(0, 77, 1'b0);
        run_phase(35, 35, 1'b0);

        // A few quiet cycles so that any result the block should not give is seen.
        repeat (DrainCycles)
            @(posedge aclk);

        if (failures == 0 && results_waiting == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
